FILE: src/sfv_pkg.sv
// ----------------------------------------------------------------------------
// sfv_pkg
// Types, codes and constants shared by the STX/ETX frame validator files.
// ----------------------------------------------------------------------------
package sfv_pkg;

  localparam logic [7:0] CHAR_STX       = 8'h02;
  localparam logic [7:0] CHAR_ETX       = 8'h03;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;
  localparam logic [7:0] MAX_LEN_RESET  = 8'd128;

  typedef enum logic [3:0] {
    PH_WAIT    = 4'b0001,
    PH_DATA    = 4'b0010,
    PH_CHECK   = 4'b0100,
    PH_GARBLED = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_COL_BYTE = 3'd1,
    EV_COL_END  = 3'd2,
    EV_VALID    = 3'd3,
    EV_GARBLED  = 3'd4
  } evt_code_t;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_BAD_CHAR = 2'd1,
    CAUSE_TOO_LONG = 2'd2,
    CAUSE_CHECKSUM = 2'd3
  } cause_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_start;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [5:0] column_index;
    logic [7:0] data_byte;
    logic [1:0] error_cause;
    logic [7:0] running_checksum;
  } result_t;

  // Returns {valid, nibble}; valid is low when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

FILE: src/sfv_rx_if.sv
// ----------------------------------------------------------------------------
// sfv_rx_if
// Handshake channel carrying one received byte word and its line start flag.
// ----------------------------------------------------------------------------
interface sfv_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_start;

  modport source (output valid, output rx_byte, output line_start, input ready);
  modport sink   (input valid, input rx_byte, input line_start, output ready);
endinterface

FILE: src/sfv_ev_if.sv
// ----------------------------------------------------------------------------
// sfv_ev_if
// Handshake channel carrying one parser event word.
// ----------------------------------------------------------------------------
interface sfv_ev_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [5:0] column_index;
  logic [7:0] data_byte;
  logic [1:0] error_cause;
  logic [7:0] running_checksum;

  modport source (output valid, output event_res, output column_index, output data_byte,
                  output error_cause, output running_checksum, input ready);
  modport sink   (input valid, input event_res, input column_index, input data_byte,
                  input error_cause, input running_checksum, output ready);
endinterface

FILE: src/sfv_in_stage.sv
// ----------------------------------------------------------------------------
// sfv_in_stage
// Input register that holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module sfv_in_stage (
  input  logic          clk,
  input  logic          rst,
  sfv_rx_if.sink        rx,
  input  logic          advance,
  output logic          item_valid,
  output sfv_pkg::item_t item
);
  import sfv_pkg::*;

  assign rx.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rx.ready) begin
      item_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.rx_byte    <= rx.rx_byte;
      item.line_start <= rx.line_start;
    end
  end

endmodule

FILE: src/sfv_parser.sv
// ----------------------------------------------------------------------------
// sfv_parser
// Frame parser state, column length limit register and per-word event logic.
// ----------------------------------------------------------------------------
module sfv_parser #(
  parameter int MAX_COLUMN_INDEX = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  logic             advance,
  input  sfv_pkg::item_t   item,
  output sfv_pkg::result_t result
);
  import sfv_pkg::*;

  localparam int CW = $clog2(MAX_COLUMN_INDEX + 1);
  localparam logic [CW-1:0] COL_MAX = CW'(MAX_COLUMN_INDEX);

  logic [7:0]    max_column_length;
  phase_t        phase, phase_next;
  logic [7:0]    xor_sum, xor_sum_next;
  logic [CW-1:0] column_count, column_count_next;
  logic [7:0]    column_length, column_length_next;
  logic [3:0]    high_nibble, high_nibble_next;
  logic          hex_digits_seen, hex_digits_seen_next;
  logic          hex_bad, hex_bad_next;

  logic [CW-1:0] idx;
  logic [CW-1:0] count_inc;
  logic [8:0]    len_inc;
  logic [4:0]    hex;
  evt_code_t     ev;
  cause_t        cause;
  logic [7:0]    c;

  always_comb begin
    c = item.rx_byte;
    phase_next           = phase;
    xor_sum_next         = xor_sum;
    column_count_next    = column_count;
    column_length_next   = column_length;
    high_nibble_next     = high_nibble;
    hex_digits_seen_next = hex_digits_seen;
    hex_bad_next         = hex_bad;
    if (item.line_start) begin
      phase_next           = PH_WAIT;
      xor_sum_next         = 8'd0;
      column_count_next    = '0;
      column_length_next   = 8'd0;
      high_nibble_next     = 4'd0;
      hex_digits_seen_next = 1'b0;
      hex_bad_next         = 1'b0;
    end
    idx       = column_count_next;
    count_inc = (column_count_next >= COL_MAX) ? COL_MAX : column_count_next + 1'b1;
    len_inc   = {1'b0, column_length_next} + 9'd1;
    hex       = hex_value(c);
    ev        = EV_IGNORED;
    cause     = CAUSE_NONE;

    case (phase_next)
      PH_WAIT: begin
        if (c == CHAR_STX) begin
          phase_next           = PH_DATA;
          xor_sum_next         = 8'd0;
          column_count_next    = '0;
          column_length_next   = 8'd0;
          high_nibble_next     = 4'd0;
          hex_digits_seen_next = 1'b0;
          hex_bad_next         = 1'b0;
          idx                  = '0;
        end
      end
      PH_DATA: begin
        if (c == CHAR_ETX || c == CHAR_COMMA) begin
          column_count_next  = count_inc;
          column_length_next = 8'd0;
          idx                = count_inc;
          ev                 = EV_COL_END;
          if (c == CHAR_ETX) begin
            phase_next           = PH_CHECK;
            hex_digits_seen_next = 1'b0;
            hex_bad_next         = 1'b0;
            high_nibble_next     = 4'd0;
          end else begin
            xor_sum_next = xor_sum_next ^ c;
          end
        end else if (c < CHAR_PRINT_LO || c > CHAR_PRINT_HI) begin
          xor_sum_next = xor_sum_next ^ c;
          phase_next   = PH_GARBLED;
          ev           = EV_GARBLED;
          cause        = CAUSE_BAD_CHAR;
        end else begin
          xor_sum_next = xor_sum_next ^ c;
          idx          = count_inc;
          if (len_inc > {1'b0, max_column_length}) begin
            phase_next = PH_GARBLED;
            ev         = EV_GARBLED;
            cause      = CAUSE_TOO_LONG;
          end else begin
            column_length_next = len_inc[7:0];
            ev                 = EV_COL_BYTE;
          end
        end
      end
      PH_CHECK: begin
        if (!hex_digits_seen_next) begin
          high_nibble_next     = hex[3:0];
          hex_bad_next         = !hex[4];
          hex_digits_seen_next = 1'b1;
        end else begin
          if (hex_bad_next || !hex[4] || {high_nibble_next, hex[3:0]} != xor_sum_next) begin
            phase_next = PH_GARBLED;
            ev         = EV_GARBLED;
            cause      = CAUSE_CHECKSUM;
          end else begin
            phase_next = PH_WAIT;
            ev         = EV_VALID;
          end
          hex_digits_seen_next = 1'b0;
          hex_bad_next         = 1'b0;
          high_nibble_next     = 4'd0;
        end
      end
      default: begin
      end
    endcase

    result.event_res        = ev;
    result.column_index     = 6'(idx);
    result.data_byte        = c;
    result.error_cause      = cause;
    result.running_checksum = xor_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_column_length <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_column_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      xor_sum         <= 8'd0;
      column_count    <= '0;
      column_length   <= 8'd0;
      high_nibble     <= 4'd0;
      hex_digits_seen <= 1'b0;
      hex_bad         <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      xor_sum         <= xor_sum_next;
      column_count    <= column_count_next;
      column_length   <= column_length_next;
      high_nibble     <= high_nibble_next;
      hex_digits_seen <= hex_digits_seen_next;
      hex_bad         <= hex_bad_next;
    end
  end

endmodule

FILE: src/sfv_out_stage.sv
// ----------------------------------------------------------------------------
// sfv_out_stage
// Result register that holds one event word until the sink takes it.
// ----------------------------------------------------------------------------
module sfv_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  sfv_pkg::result_t result,
  output logic             advance,
  sfv_ev_if.source         ev
);
  import sfv_pkg::*;

  result_t held;

  assign advance = item_valid && (!ev.valid || ev.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else if (!ev.valid || ev.ready) begin
      ev.valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= result;
    end
  end

  assign ev.event_res        = held.event_res;
  assign ev.column_index     = held.column_index;
  assign ev.data_byte        = held.data_byte;
  assign ev.error_cause      = held.error_cause;
  assign ev.running_checksum = held.running_checksum;

endmodule

FILE: src/stx_etx_frame_validator.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_validator
// STX/ETX framed ASCII line validator with comma columns and XOR checksum.
// ----------------------------------------------------------------------------
//   Channel  Dir  Contents
//   rx       in   rx_byte, line_start
//   ev       out  event_res, column_index, data_byte, error_cause, running_checksum
//   cfg      in   cfg_write, cfg_data (max_column_length, reset 128)
//
// Each word is held in the input register and then parsed into the result
// register, from which its event word is offered. One word can be accepted
// every cycle while the event output is not stalled.
// Reset is synchronous and returns the parser to waiting for STX.
// A stalled result holds both registers; an empty input register still takes one word.
// ----------------------------------------------------------------------------
module stx_etx_frame_validator #(
  parameter int MAX_COLUMN_INDEX = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  sfv_rx_if.sink     rx,
  sfv_ev_if.source   ev
);
  import sfv_pkg::*;

  logic    item_valid;
  logic    advance;
  item_t   item;
  result_t result;

  sfv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sfv_parser #(
    .MAX_COLUMN_INDEX (MAX_COLUMN_INDEX)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  sfv_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .ev         (ev)
  );

endmodule

FILE: dv/stx_etx_frame_validator_tb.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_validator_tb
// Self-checking bench for the STX/ETX frame validator. Bytes are sent as
// framed lines with random content, flaws and noise under several column
// length limits. Both channels idle at random. A scoreboard class predicts
// each event word and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module stx_etx_frame_validator_tb;
  import sfv_pkg::*;

  localparam logic [5:0] COL_INDEX_CAP = 6'd63;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 30;

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CHAR,
    FLAW_LONG,
    FLAW_BAD_SUM,
    FLAW_NON_HEX,
    FLAW_CUT,
    FLAW_NOISE
  } frame_flaw_t;

  class frame_event_tracker;
    phase_t     ph;
    logic [7:0] xsum;
    logic [5:0] ncols;
    logic [7:0] col_len;
    logic [3:0] hi_nib;
    bit         digit_seen;
    bit         digit_bad;
    logic [7:0] max_len;
    result_t    expected_events[$];
    int         mismatches;

    function new();
      max_len = MAX_LEN_RESET;
      mismatches = 0;
      restart_parse();
    endfunction

    function void restart_parse();
      ph = PH_WAIT;
      xsum = 8'd0;
      ncols = 6'd0;
      col_len = 8'd0;
      hi_nib = 4'd0;
      digit_seen = 0;
      digit_bad = 0;
    endfunction

    function void take_byte(logic [7:0] c, logic ls);
      result_t     r;
      int unsigned len;
      logic [3:0]  nib;
      bit          hex_ok;
      r.event_res = EV_IGNORED;
      r.error_cause = CAUSE_NONE;
      r.data_byte = c;
      if (ls) restart_parse();
      r.column_index = ncols;
      case (ph)
        PH_WAIT: begin
          if (c == CHAR_STX) begin
            restart_parse();
            ph = PH_DATA;
            r.column_index = 6'd0;
          end
        end
        PH_DATA: begin
          if (c == CHAR_ETX || c == CHAR_COMMA) begin
            ncols = (ncols >= COL_INDEX_CAP) ? COL_INDEX_CAP : ncols + 6'd1;
            col_len = 8'd0;
            r.column_index = ncols;
            r.event_res = EV_COL_END;
            if (c == CHAR_ETX) begin
              ph = PH_CHECK;
              digit_seen = 0;
              digit_bad = 0;
              hi_nib = 4'd0;
            end else begin
              xsum ^= c;
            end
          end else if (c < CHAR_PRINT_LO || c > CHAR_PRINT_HI) begin
            xsum ^= c;
            ph = PH_GARBLED;
            r.event_res = EV_GARBLED;
            r.error_cause = CAUSE_BAD_CHAR;
          end else begin
            len = col_len + 32'd1;
            xsum ^= c;
            r.column_index = (ncols >= COL_INDEX_CAP) ? COL_INDEX_CAP : ncols + 6'd1;
            if (len > max_len) begin
              ph = PH_GARBLED;
              r.event_res = EV_GARBLED;
              r.error_cause = CAUSE_TOO_LONG;
            end else begin
              col_len = 8'(len);
              r.event_res = EV_COL_BYTE;
            end
          end
        end
        PH_CHECK: begin
          hex_ok = 1;
          if (c >= 8'h30 && c <= 8'h39) begin
            nib = c[3:0];
          end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            nib = c[3:0] + 4'd9;
          end else begin
            nib = 4'd0;
            hex_ok = 0;
          end
          if (!digit_seen) begin
            hi_nib = nib;
            digit_bad = !hex_ok;
            digit_seen = 1;
          end else begin
            if (digit_bad || !hex_ok || {hi_nib, nib} != xsum) begin
              ph = PH_GARBLED;
              r.event_res = EV_GARBLED;
              r.error_cause = CAUSE_CHECKSUM;
            end else begin
              ph = PH_WAIT;
              r.event_res = EV_VALID;
            end
            digit_seen = 0;
            digit_bad = 0;
            hi_nib = 4'd0;
          end
        end
        default: ;
      endcase
      r.running_checksum = xsum;
      expected_events.push_back(r);
    endfunction

    function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
      if (got === want) return 0;
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      return 1;
    endfunction

    function void match_event(result_t got);
      result_t want;
      bit      bad;
      if (expected_events.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: event word with none expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      bad = field_differs("event_res", 8'(want.event_res), 8'(got.event_res));
      bad |= field_differs("column_index", 8'(want.column_index), 8'(got.column_index));
      bad |= field_differs("data_byte", want.data_byte, got.data_byte);
      bad |= field_differs("error_cause", 8'(want.error_cause), 8'(got.error_cause));
      bad |= field_differs("running_checksum", want.running_checksum,
                           got.running_checksum);
      if (bad) mismatches++;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;

  sfv_rx_if rx_ch();
  sfv_ev_if ev_ch();

  stx_etx_frame_validator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .ev        (ev_ch)
  );

  frame_event_tracker tracker;
  logic [7:0]  line_q[$];
  logic [7:0]  frame_sum;
  logic [7:0]  cur_limit = MAX_LEN_RESET;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int unsigned sent_count = 0;
  result_t     seen_word;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && ev_ch.valid && ev_ch.ready) begin
      seen_word.event_res = ev_ch.event_res;
      seen_word.column_index = ev_ch.column_index;
      seen_word.data_byte = ev_ch.data_byte;
      seen_word.error_cause = ev_ch.error_cause;
      seen_word.running_checksum = ev_ch.running_checksum;
      tracker.match_event(seen_word);
    end
    if (rst) begin
      ev_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      ev_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      ev_ch.ready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      ev_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (ev_ch.valid && ev_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return (lower ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic ls);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.line_start <= ls;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    tracker.take_byte(b, ls);
    sent_count++;
  endtask

  task automatic send_line(input bit fixed_start);
    logic ls;
    foreach (line_q[i]) begin
      if (fixed_start) ls = (i == 0);
      else if (i == 0) ls = ($urandom_range(0, 9) != 0);
      else ls = ($urandom_range(0, 49) == 0);
      send_word(line_q[i], ls);
    end
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic add_data(input logic [7:0] b);
    line_q.push_back(b);
    frame_sum ^= b;
  endtask

  task automatic build_frame(input frame_flaw_t flaw);
    int unsigned ncol, width, long_col, stx_pos, cut;
    int unsigned max_width;
    logic [7:0]  b, sum;
    line_q.delete();
    frame_sum = 8'd0;
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b != CHAR_STX) line_q.push_back(b);
    end
    stx_pos = line_q.size();
    line_q.push_back(CHAR_STX);
    if ($urandom_range(0, 39) == 0) begin
      ncol = $urandom_range(60, 70);
      max_width = 1;
    end else begin
      ncol = $urandom_range(1, 5);
      max_width = 6;
    end
    if (max_width > cur_limit) max_width = cur_limit;
    long_col = $urandom_range(0, ncol - 1);
    for (int col = 0; col < ncol; col++) begin
      if (col > 0) add_data(CHAR_COMMA);
      if (flaw == FLAW_LONG && col == long_col) width = cur_limit + 1;
      else width = $urandom_range(0, max_width);
      repeat (width) begin
        b = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
        if (b == CHAR_COMMA) b = 8'h2E;
        add_data(b);
      end
    end
    if (flaw == FLAW_BAD_CHAR) begin
      do b = 8'($urandom_range(0, 255));
      while ((b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI) || b == CHAR_ETX);
      line_q.insert($urandom_range(stx_pos + 1, line_q.size()), b);
    end
    line_q.push_back(CHAR_ETX);
    sum = frame_sum;
    if (flaw == FLAW_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
    line_q.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
    line_q.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
    if (flaw == FLAW_NON_HEX) begin
      do b = 8'($urandom_range(0, 255));
      while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66));
      line_q[line_q.size() - 1 - $urandom_range(0, 1)] = b;
    end
    if (flaw == FLAW_CUT) begin
      cut = $urandom_range(1, line_q.size() - 1);
      repeat (cut) void'(line_q.pop_back());
    end
    if ($urandom_range(0, 9) == 0) line_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input logic [7:0] limit, input int unsigned n_items,
                           input int gap, input int stall);
    int unsigned stop_at;
    int unsigned pick;
    frame_flaw_t flaw;
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.max_len = limit;
    cur_limit = limit;
    gap_pct = gap;
    stall_pct = stall;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) flaw = FLAW_NONE;
      else if (pick < 77) flaw = FLAW_BAD_CHAR;
      else if (pick < 81) flaw = (limit <= 32) ? FLAW_LONG : FLAW_NONE;
      else if (pick < 86) flaw = FLAW_BAD_SUM;
      else if (pick < 90) flaw = FLAW_NON_HEX;
      else if (pick < 95) flaw = FLAW_CUT;
      else flaw = FLAW_NOISE;
      build_frame(flaw);
      send_line(1'b0);
    end
  endtask

  initial begin
    tracker = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= MAX_LEN_RESET;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= 8'd0;
    rx_ch.line_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    line_q = '{8'h00, 8'hFF, CHAR_ETX};
    send_line(1'b1);
    line_q = '{CHAR_STX, CHAR_PRINT_LO, CHAR_PRINT_HI, CHAR_COMMA, 8'h7A, CHAR_ETX,
               8'h30, 8'h38};
    send_line(1'b1);
    line_q = '{CHAR_STX, 8'h61, 8'h7F, 8'h62, CHAR_ETX};
    send_line(1'b1);
    line_q = '{CHAR_STX, CHAR_ETX, 8'h66, 8'h66};
    send_line(1'b1);
    line_q = '{CHAR_STX, CHAR_COMMA, CHAR_ETX, 8'h47, 8'h43};
    send_line(1'b1);
    line_q = '{CHAR_STX, 8'h4A, CHAR_ETX, 8'h34, 8'h61};
    send_line(1'b1);

    run_phase(8'd0, 40, 20, 20);
    run_phase(8'd1, 60, 30, 0);
    run_phase(8'd255, 40, 0, 40);
    build_frame(FLAW_LONG);
    send_line(1'b1);
    run_phase(8'($urandom_range(2, 16)), 160, 30, 30);
    run_phase(8'($urandom_range(17, 254)), 150, 10, 10);

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sfv_pkg.sv
src/sfv_rx_if.sv
src/sfv_ev_if.sv
src/sfv_in_stage.sv
src/sfv_parser.sv
src/sfv_out_stage.sv
src/stx_etx_frame_validator.sv
dv/stx_etx_frame_validator_tb.sv
